// File: rtl/tskf_pkg.sv
// Shared types, codes and the microprogram of the two-state Kalman filter.
`default_nettype none
package tskf_pkg;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_NEG = 3'd2,
    OP_MUL = 3'd3,
    OP_DIV = 3'd4,
    OP_CHK = 3'd5
  } op_e;

  typedef enum logic [4:0] {
    S_XA   = 5'd0,
    S_XD   = 5'd1,
    S_P0   = 5'd2,
    S_P1   = 5'd3,
    S_P2   = 5'd4,
    S_P3   = 5'd5,
    S_QA   = 5'd6,
    S_QD   = 5'd7,
    S_RA   = 5'd8,
    S_RD   = 5'd9,
    S_DT   = 5'd10,
    S_ZA   = 5'd11,
    S_ZD   = 5'd12,
    S_ONE  = 5'd13,
    S_ZERO = 5'd14,
    S_T0   = 5'd15,
    S_T1   = 5'd16,
    S_T2   = 5'd17,
    S_T3   = 5'd18,
    S_T4   = 5'd19,
    S_T5   = 5'd20,
    S_T6   = 5'd21,
    S_T7   = 5'd22,
    S_T8   = 5'd23
  } src_e;

  typedef enum logic [1:0] {
    ACT_PREDICT = 2'd0,
    ACT_UPDATE  = 2'd1,
    ACT_RESET   = 2'd2,
    ACT_NONE    = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    REG_Q_ANGLE    = 3'd0,
    REG_Q_DISTANCE = 3'd1,
    REG_R_ANGLE    = 3'd2,
    REG_R_DISTANCE = 3'd3,
    REG_P_ANGLE    = 3'd4,
    REG_P_DISTANCE = 3'd5,
    REG_X_ANGLE    = 3'd6,
    REG_X_DISTANCE = 3'd7
  } reg_e;

  typedef struct packed {
    op_e  op;
    src_e a;
    src_e b;
    src_e dst;
    logic last;
  } uop_t;

  typedef struct packed {
    logic start;
    op_e  op;
  } alu_req_t;

  localparam int PC_BITS = 7;
  localparam logic [PC_BITS-1:0] PC_PREDICT = 7'd0;
  localparam logic [PC_BITS-1:0] PC_UPDATE  = 7'd12;

  function automatic uop_t ucode(input logic [PC_BITS-1:0] pc);
    uop_t u;
    unique case (pc)
      // predict
      7'd0:  u = '{OP_MUL, S_DT,   S_P2,   S_T0, 1'b0};
      7'd1:  u = '{OP_SUB, S_P0,   S_T0,   S_T0, 1'b0};
      7'd2:  u = '{OP_MUL, S_DT,   S_P3,   S_T1, 1'b0};
      7'd3:  u = '{OP_SUB, S_P1,   S_T1,   S_T1, 1'b0};
      7'd4:  u = '{OP_MUL, S_DT,   S_T1,   S_T2, 1'b0};
      7'd5:  u = '{OP_SUB, S_T0,   S_T2,   S_T0, 1'b0};
      7'd6:  u = '{OP_MUL, S_DT,   S_P3,   S_T2, 1'b0};
      7'd7:  u = '{OP_SUB, S_P2,   S_T2,   S_T2, 1'b0};
      7'd8:  u = '{OP_ADD, S_T0,   S_QA,   S_P0, 1'b0};
      7'd9:  u = '{OP_ADD, S_T1,   S_ZERO, S_P1, 1'b0};
      7'd10: u = '{OP_ADD, S_T2,   S_ZERO, S_P2, 1'b0};
      7'd11: u = '{OP_ADD, S_P3,   S_QD,   S_P3, 1'b1};
      // update: innovation, S and its determinant
      7'd12: u = '{OP_SUB, S_ZA,   S_XA,   S_T0, 1'b0};
      7'd13: u = '{OP_SUB, S_ZD,   S_XD,   S_T1, 1'b0};
      7'd14: u = '{OP_ADD, S_P0,   S_RA,   S_T2, 1'b0};
      7'd15: u = '{OP_ADD, S_P3,   S_RD,   S_T3, 1'b0};
      7'd16: u = '{OP_MUL, S_T2,   S_T3,   S_T4, 1'b0};
      7'd17: u = '{OP_MUL, S_P1,   S_P2,   S_T5, 1'b0};
      7'd18: u = '{OP_SUB, S_T4,   S_T5,   S_T4, 1'b0};
      7'd19: u = '{OP_CHK, S_T4,   S_ZERO, S_T8, 1'b0};
      // inverse of S
      7'd20: u = '{OP_DIV, S_T3,   S_T4,   S_T5, 1'b0};
      7'd21: u = '{OP_NEG, S_P1,   S_ZERO, S_T6, 1'b0};
      7'd22: u = '{OP_DIV, S_T6,   S_T4,   S_T6, 1'b0};
      7'd23: u = '{OP_NEG, S_P2,   S_ZERO, S_T7, 1'b0};
      7'd24: u = '{OP_DIV, S_T7,   S_T4,   S_T7, 1'b0};
      7'd25: u = '{OP_DIV, S_T2,   S_T4,   S_T8, 1'b0};
      // gain
      7'd26: u = '{OP_MUL, S_P0,   S_T5,   S_T2, 1'b0};
      7'd27: u = '{OP_MUL, S_P1,   S_T7,   S_T3, 1'b0};
      7'd28: u = '{OP_ADD, S_T2,   S_T3,   S_T2, 1'b0};
      7'd29: u = '{OP_MUL, S_P0,   S_T6,   S_T3, 1'b0};
      7'd30: u = '{OP_MUL, S_P1,   S_T8,   S_T4, 1'b0};
      7'd31: u = '{OP_ADD, S_T3,   S_T4,   S_T3, 1'b0};
      7'd32: u = '{OP_MUL, S_P2,   S_T5,   S_T4, 1'b0};
      7'd33: u = '{OP_MUL, S_P3,   S_T7,   S_T5, 1'b0};
      7'd34: u = '{OP_ADD, S_T4,   S_T5,   S_T4, 1'b0};
      7'd35: u = '{OP_MUL, S_P2,   S_T6,   S_T5, 1'b0};
      7'd36: u = '{OP_MUL, S_P3,   S_T8,   S_T6, 1'b0};
      7'd37: u = '{OP_ADD, S_T5,   S_T6,   S_T5, 1'b0};
      // estimate
      7'd38: u = '{OP_MUL, S_T2,   S_T0,   S_T6, 1'b0};
      7'd39: u = '{OP_MUL, S_T3,   S_T1,   S_T7, 1'b0};
      7'd40: u = '{OP_ADD, S_T6,   S_T7,   S_T6, 1'b0};
      7'd41: u = '{OP_ADD, S_XA,   S_T6,   S_XA, 1'b0};
      7'd42: u = '{OP_MUL, S_T4,   S_T0,   S_T6, 1'b0};
      7'd43: u = '{OP_MUL, S_T5,   S_T1,   S_T7, 1'b0};
      7'd44: u = '{OP_ADD, S_T6,   S_T7,   S_T6, 1'b0};
      7'd45: u = '{OP_ADD, S_XD,   S_T6,   S_XD, 1'b0};
      // I - K
      7'd46: u = '{OP_SUB, S_ONE,  S_T2,   S_T0, 1'b0};
      7'd47: u = '{OP_NEG, S_T3,   S_ZERO, S_T1, 1'b0};
      7'd48: u = '{OP_NEG, S_T4,   S_ZERO, S_T2, 1'b0};
      7'd49: u = '{OP_SUB, S_ONE,  S_T5,   S_T3, 1'b0};
      // covariance
      7'd50: u = '{OP_MUL, S_T0,   S_P0,   S_T4, 1'b0};
      7'd51: u = '{OP_MUL, S_T1,   S_P2,   S_T5, 1'b0};
      7'd52: u = '{OP_ADD, S_T4,   S_T5,   S_T4, 1'b0};
      7'd53: u = '{OP_MUL, S_T0,   S_P1,   S_T5, 1'b0};
      7'd54: u = '{OP_MUL, S_T1,   S_P3,   S_T6, 1'b0};
      7'd55: u = '{OP_ADD, S_T5,   S_T6,   S_T5, 1'b0};
      7'd56: u = '{OP_MUL, S_T2,   S_P0,   S_T6, 1'b0};
      7'd57: u = '{OP_MUL, S_T3,   S_P2,   S_T7, 1'b0};
      7'd58: u = '{OP_ADD, S_T6,   S_T7,   S_T6, 1'b0};
      7'd59: u = '{OP_MUL, S_T2,   S_P1,   S_T7, 1'b0};
      7'd60: u = '{OP_MUL, S_T3,   S_P3,   S_T8, 1'b0};
      7'd61: u = '{OP_ADD, S_T7,   S_T8,   S_T7, 1'b0};
      7'd62: u = '{OP_ADD, S_T4,   S_ZERO, S_P0, 1'b0};
      7'd63: u = '{OP_ADD, S_T5,   S_ZERO, S_P1, 1'b0};
      7'd64: u = '{OP_ADD, S_T6,   S_ZERO, S_P2, 1'b0};
      7'd65: u = '{OP_ADD, S_T7,   S_ZERO, S_P3, 1'b1};
      default: u = '{OP_ADD, S_ZERO, S_ZERO, S_T8, 1'b1};
    endcase
    return u;
  endfunction

endpackage
`default_nettype wire

// File: rtl/two_state_kalman_filter_top.sv
// Top level of the two-state Kalman filter: registers, state and microsequencer.
//
//  channel  dir  handshake                      payload
//  s_axis   in   s_axis_tvalid / s_axis_tready  tdata dt, z_angle, z_distance; tuser action
//  m_axis   out  m_axis_tvalid / m_axis_tready  tdata estimate, variances; tuser update_skipped
//  cfg      in   cfg_we_i                       cfg_idx_i, cfg_wdata_i
//
// One word in at a time; the microprogram runs on the shared unit. Multiplies sum four 32x32
// partial products, divides produce one quotient bit a cycle. An update is dropped, and the
// state kept, when det S is too small. Reset loads the configured defaults.
// The result register holds a finished word, so the next input is taken while it waits;
// a later result stalls until m_axis_tready frees it.
`default_nettype none
module two_state_kalman_filter_top #(
  parameter int WORD_BITS = 48,
  parameter int FRAC_BITS = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // dt [46:0], z_angle [94:47], z_distance [142:95], zero pad [143]
  input  wire logic [143:0]  s_axis_tdata,
  // action [1:0]
  input  wire logic [1:0]    s_axis_tuser,
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // out_angle [47:0], out_distance [95:48], out_var_angle [143:96], out_var_distance [191:144]
  output logic [191:0]       m_axis_tdata,
  // update_skipped [0]
  output logic [0:0]         m_axis_tuser,
  input  wire logic          cfg_we_i,
  input  wire logic [2:0]    cfg_idx_i,
  input  wire logic [47:0]   cfg_wdata_i
);
  import tskf_pkg::*;

  localparam int W = WORD_BITS;
  localparam int F = FRAC_BITS;
  localparam logic signed [64:0] WMAX65 = (65'sd1 <<< (W - 1)) - 65'sd1;
  localparam logic signed [64:0] WMIN65 = -WMAX65 - 65'sd1;
  localparam logic signed [64:0] DETMIN65 =
    65'(((64'd1 << F) + 64'd50000) / 64'd100000);
  localparam logic signed [64:0] ONE65 = (F >= W - 1) ? WMAX65 : (65'sd1 <<< F);
  localparam logic [W-1:0] ONE = ONE65[W-1:0];

  localparam logic [46:0] Q_DEF  = 47'd429496730;
  localparam logic [46:0] RA_DEF = 47'd10737418;
  localparam logic [46:0] RD_DEF = 47'd4294967;
  localparam logic [46:0] PA_DEF = 47'd214748365;
  localparam logic [46:0] PD_DEF = 47'd7301444;
  localparam logic [47:0] XA_DEF = 48'd0;
  localparam logic [47:0] XD_DEF = 48'd4294967296;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FETCH = 4'b0010,
    ST_EXEC  = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

  function automatic logic [W-1:0] sat_word(input logic signed [64:0] v);
    if (v > WMAX65) return WMAX65[W-1:0];
    if (v < WMIN65) return WMIN65[W-1:0];
    return v[W-1:0];
  endfunction

  function automatic logic [W-1:0] from_u47(input logic [46:0] v);
    return sat_word(signed'({18'd0, v}));
  endfunction

  function automatic logic [W-1:0] from_s48(input logic [47:0] v);
    return sat_word(signed'({{17{v[47]}}, v}));
  endfunction

  function automatic logic signed [64:0] ext(input logic [W-1:0] v);
    return signed'({{(65 - W){v[W-1]}}, v});
  endfunction

  function automatic logic [47:0] to_out(input logic [W-1:0] v);
    logic signed [64:0] e;
    e = ext(v);
    return e[47:0];
  endfunction

  // configuration
  logic [46:0] qa_q, qd_q, ra_q, rd_q, pa_q, pd_q;
  logic [47:0] xa0_q, xd0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qa_q  <= Q_DEF;
      qd_q  <= Q_DEF;
      ra_q  <= RA_DEF;
      rd_q  <= RD_DEF;
      pa_q  <= PA_DEF;
      pd_q  <= PD_DEF;
      xa0_q <= XA_DEF;
      xd0_q <= XD_DEF;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_idx_i))
        REG_Q_ANGLE:    qa_q  <= cfg_wdata_i[46:0];
        REG_Q_DISTANCE: qd_q  <= cfg_wdata_i[46:0];
        REG_R_ANGLE:    ra_q  <= cfg_wdata_i[46:0];
        REG_R_DISTANCE: rd_q  <= cfg_wdata_i[46:0];
        REG_P_ANGLE:    pa_q  <= cfg_wdata_i[46:0];
        REG_P_DISTANCE: pd_q  <= cfg_wdata_i[46:0];
        REG_X_ANGLE:    xa0_q <= cfg_wdata_i;
        REG_X_DISTANCE: xd0_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // filter state, latched inputs and scratch
  logic [W-1:0] xa_q, xd_q, p0_q, p1_q, p2_q, p3_q;
  logic [W-1:0] dt_q, za_q, zd_q;
  logic [W-1:0] t0_q, t1_q, t2_q, t3_q, t4_q, t5_q, t6_q, t7_q, t8_q;

  state_e             st_q, st_d;
  logic [PC_BITS-1:0] pc_q, pc_d;
  logic               skip_q, skip_d;
  logic               ovalid_q, ovalid_d;
  logic [191:0]       odata_q;
  logic               oskip_q;

  uop_t         uop;
  alu_req_t     alu_req;
  logic [W-1:0] opa, opb, alu_y;
  logic         alu_done;
  logic         accept, det_small, load_init, out_load, wr_en;

  function automatic logic [W-1:0] src_val(input src_e s);
    logic [W-1:0] v;
    unique case (s)
      S_XA:    v = xa_q;
      S_XD:    v = xd_q;
      S_P0:    v = p0_q;
      S_P1:    v = p1_q;
      S_P2:    v = p2_q;
      S_P3:    v = p3_q;
      S_QA:    v = from_u47(qa_q);
      S_QD:    v = from_u47(qd_q);
      S_RA:    v = from_u47(ra_q);
      S_RD:    v = from_u47(rd_q);
      S_DT:    v = dt_q;
      S_ZA:    v = za_q;
      S_ZD:    v = zd_q;
      S_ONE:   v = ONE;
      S_T0:    v = t0_q;
      S_T1:    v = t1_q;
      S_T2:    v = t2_q;
      S_T3:    v = t3_q;
      S_T4:    v = t4_q;
      S_T5:    v = t5_q;
      S_T6:    v = t6_q;
      S_T7:    v = t7_q;
      S_T8:    v = t8_q;
      default: v = '0;
    endcase
    return v;
  endfunction

  always_comb begin
    uop       = ucode(pc_q);
    opa       = src_val(uop.a);
    opb       = src_val(uop.b);
    det_small = (ext(opa) > -DETMIN65) && (ext(opa) < DETMIN65);
  end

  assign s_axis_tready = (st_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    st_d          = st_q;
    pc_d          = pc_q;
    skip_d        = skip_q;
    ovalid_d      = ovalid_q && !m_axis_tready;
    alu_req.start = 1'b0;
    alu_req.op    = uop.op;
    load_init     = 1'b0;
    out_load      = 1'b0;
    wr_en         = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (accept) begin
          skip_d = 1'b0;
          unique case (action_e'(s_axis_tuser))
            ACT_PREDICT: begin
              pc_d = PC_PREDICT;
              st_d = ST_FETCH;
            end
            ACT_UPDATE: begin
              pc_d = PC_UPDATE;
              st_d = ST_FETCH;
            end
            ACT_RESET: begin
              load_init = 1'b1;
              st_d      = ST_DONE;
            end
            default: st_d = ST_DONE;
          endcase
        end
      end
      ST_FETCH: begin
        if (uop.op == OP_CHK) begin
          // determinant too small: drop the update, keep the state
          if (det_small) begin
            skip_d = 1'b1;
            st_d   = ST_DONE;
          end else begin
            pc_d = pc_q + PC_BITS'(1);
          end
        end else begin
          alu_req.start = 1'b1;
          st_d          = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (alu_done) begin
          wr_en = 1'b1;
          if (uop.last) begin
            st_d = ST_DONE;
          end else begin
            pc_d = pc_q + PC_BITS'(1);
            st_d = ST_FETCH;
          end
        end
      end
      ST_DONE: begin
        // hold until the result register is free
        if (!ovalid_q || m_axis_tready) begin
          out_load = 1'b1;
          ovalid_d = 1'b1;
          st_d     = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  tskf_alu #(
    .WORD_BITS(W),
    .FRAC_BITS(F)
  ) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (opa),
    .b_i    (opb),
    .done_o (alu_done),
    .y_o    (alu_y)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_IDLE;
      pc_q     <= '0;
      skip_q   <= 1'b0;
      ovalid_q <= 1'b0;
      xa_q     <= from_s48(XA_DEF);
      xd_q     <= from_s48(XD_DEF);
      p0_q     <= from_u47(PA_DEF);
      p1_q     <= '0;
      p2_q     <= '0;
      p3_q     <= from_u47(PD_DEF);
    end else begin
      st_q     <= st_d;
      pc_q     <= pc_d;
      skip_q   <= skip_d;
      ovalid_q <= ovalid_d;
      if (load_init) begin
        xa_q <= from_s48(xa0_q);
        xd_q <= from_s48(xd0_q);
        p0_q <= from_u47(pa_q);
        p1_q <= '0;
        p2_q <= '0;
        p3_q <= from_u47(pd_q);
      end else if (wr_en) begin
        unique case (uop.dst)
          S_XA:    xa_q <= alu_y;
          S_XD:    xd_q <= alu_y;
          S_P0:    p0_q <= alu_y;
          S_P1:    p1_q <= alu_y;
          S_P2:    p2_q <= alu_y;
          S_P3:    p3_q <= alu_y;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      dt_q <= from_u47(s_axis_tdata[46:0]);
      za_q <= from_s48(s_axis_tdata[94:47]);
      zd_q <= from_s48(s_axis_tdata[142:95]);
    end
    if (wr_en) begin
      unique case (uop.dst)
        S_T0:    t0_q <= alu_y;
        S_T1:    t1_q <= alu_y;
        S_T2:    t2_q <= alu_y;
        S_T3:    t3_q <= alu_y;
        S_T4:    t4_q <= alu_y;
        S_T5:    t5_q <= alu_y;
        S_T6:    t6_q <= alu_y;
        S_T7:    t7_q <= alu_y;
        S_T8:    t8_q <= alu_y;
        default: ;
      endcase
    end
    if (out_load) begin
      odata_q <= {to_out(p3_q), to_out(p0_q), to_out(xd_q), to_out(xa_q)};
      oskip_q <= skip_q;
    end
  end

  assign m_axis_tvalid   = ovalid_q;
  assign m_axis_tdata    = odata_q;
  assign m_axis_tuser[0] = oskip_q;

endmodule
`default_nettype wire

// File: rtl/tskf_alu.sv
// Shared fixed-point unit: saturating add, subtract, negate, multiply and divide.
`default_nettype none
module tskf_alu #(
  parameter int WORD_BITS = 48,
  parameter int FRAC_BITS = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire tskf_pkg::alu_req_t       req_i,
  input  wire logic [WORD_BITS-1:0]     a_i,
  input  wire logic [WORD_BITS-1:0]     b_i,
  output logic                          done_o,
  output logic [WORD_BITS-1:0]          y_o
);
  import tskf_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int F  = FRAC_BITS;
  localparam int NB = W + F;
  localparam int CW = $clog2(NB);
  localparam logic [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};

  typedef enum logic [4:0] {
    A_IDLE = 5'b00001,
    A_MUL  = 5'b00010,
    A_MULF = 5'b00100,
    A_DIV  = 5'b01000,
    A_DIVF = 5'b10000
  } alu_st_e;

  alu_st_e          st_q, st_d;
  logic             done_q, done_d;
  logic [W-1:0]     y_q, y_d;
  logic [63:0]      ma_q, ma_d, mb_q, mb_d;
  logic             neg_q, neg_d;
  logic [127:0]     acc_q, acc_d;
  logic [1:0]       mcnt_q, mcnt_d;
  logic [W-1:0]     ud_q, ud_d;
  logic [W:0]       rem_q, rem_d;
  logic [NB-1:0]    num_q, num_d, quo_q, quo_d;
  logic [CW-1:0]    dcnt_q, dcnt_d;

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? W'(-v) : v;
  endfunction

  function automatic logic [W-1:0] sat_mag(input logic [127:0] m, input logic neg);
    logic [127:0] lim;
    logic [W-1:0] r;
    lim = neg ? 128'(WMIN) : 128'(WMAX);
    r   = (m > lim) ? lim[W-1:0] : m[W-1:0];
    return neg ? W'(-r) : r;
  endfunction

  function automatic logic [W-1:0] sat_sum(input logic [W:0] s);
    if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
    return s[W-1:0];
  endfunction

  logic [31:0]  pa, pb;
  logic [63:0]  prod;
  logic [127:0] pshift, rnd_m;
  logic [W:0]   r2;
  logic         ge;
  logic [NB:0]  qr;
  logic         qup;

  always_comb begin
    pa   = mcnt_q[1] ? ma_q[63:32] : ma_q[31:0];
    pb   = mcnt_q[0] ? mb_q[63:32] : mb_q[31:0];
    prod = 64'(pa) * 64'(pb);
    unique case (mcnt_q)
      2'd0:    pshift = 128'(prod);
      2'd3:    pshift = 128'(prod) << 64;
      default: pshift = 128'(prod) << 32;
    endcase
    rnd_m = (acc_q + (128'd1 << (F - 1))) >> F;
    r2    = {rem_q[W-1:0], num_q[NB-1]};
    ge    = r2 >= {1'b0, ud_q};
    qup   = {rem_q, 1'b0} >= {2'b00, ud_q};
    qr    = {1'b0, quo_q} + (NB+1)'(qup);
  end

  always_comb begin
    st_d   = st_q;
    done_d = 1'b0;
    y_d    = y_q;
    ma_d   = ma_q;
    mb_d   = mb_q;
    neg_d  = neg_q;
    acc_d  = acc_q;
    mcnt_d = mcnt_q;
    ud_d   = ud_q;
    rem_d  = rem_q;
    num_d  = num_q;
    quo_d  = quo_q;
    dcnt_d = dcnt_q;
    unique case (st_q)
      A_IDLE: begin
        if (req_i.start) begin
          neg_d = a_i[W-1] ^ b_i[W-1];
          unique case (req_i.op)
            OP_SUB: begin
              y_d    = sat_sum({a_i[W-1], a_i} - {b_i[W-1], b_i});
              done_d = 1'b1;
            end
            OP_NEG: begin
              y_d    = (a_i == WMIN) ? WMAX : W'(-a_i);
              done_d = 1'b1;
            end
            OP_MUL: begin
              ma_d   = 64'(mag(a_i));
              mb_d   = 64'(mag(b_i));
              acc_d  = '0;
              mcnt_d = '0;
              st_d   = A_MUL;
            end
            OP_DIV: begin
              ud_d = mag(b_i);
              if (b_i == '0) begin
                // divide by zero: zero stays zero, anything else pins to the rail
                y_d    = (a_i == '0) ? '0 : (a_i[W-1] ? WMIN : WMAX);
                done_d = 1'b1;
              end else begin
                num_d  = {mag(a_i), {F{1'b0}}};
                rem_d  = '0;
                quo_d  = '0;
                dcnt_d = '0;
                st_d   = A_DIV;
              end
            end
            default: begin
              y_d    = sat_sum({a_i[W-1], a_i} + {b_i[W-1], b_i});
              done_d = 1'b1;
            end
          endcase
        end
      end
      A_MUL: begin
        acc_d  = acc_q + pshift;
        mcnt_d = mcnt_q + 2'd1;
        if (mcnt_q == 2'd3) st_d = A_MULF;
      end
      A_MULF: begin
        y_d    = sat_mag(rnd_m, neg_q);
        done_d = 1'b1;
        st_d   = A_IDLE;
      end
      A_DIV: begin
        rem_d  = ge ? (r2 - {1'b0, ud_q}) : r2;
        quo_d  = {quo_q[NB-2:0], ge};
        num_d  = num_q << 1;
        dcnt_d = dcnt_q + CW'(1);
        if (dcnt_q == CW'(NB - 1)) st_d = A_DIVF;
      end
      A_DIVF: begin
        y_d    = sat_mag(128'(qr), neg_q);
        done_d = 1'b1;
        st_d   = A_IDLE;
      end
      default: st_d = A_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= A_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    y_q    <= y_d;
    ma_q   <= ma_d;
    mb_q   <= mb_d;
    neg_q  <= neg_d;
    acc_q  <= acc_d;
    mcnt_q <= mcnt_d;
    ud_q   <= ud_d;
    rem_q  <= rem_d;
    num_q  <= num_d;
    quo_q  <= quo_d;
    dcnt_q <= dcnt_d;
  end

  assign done_o = done_q;
  assign y_o    = y_q;

endmodule
`default_nettype wire
